// File: sv/base32_strict_decoder_core_macros.svh
// ============================================================================
// Assertion macros for the base32 strict decoder core
// Shared property wrappers, clocked on clk and disabled in reset.
// ============================================================================
`ifndef BASE32_STRICT_DECODER_CORE_MACROS_SVH
`define BASE32_STRICT_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define B32D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B32D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/b32d_pkg.sv
// ============================================================================
// b32d_pkg
// Types, status codes and character constants of the base32 decoder.
// ============================================================================
package b32d_pkg;

    localparam int SYMBOL_BITS  = 5;
    localparam int BYTE_BITS    = 8;
    localparam int LETTER_COUNT = 26;

    localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
    localparam logic [7:0] CHAR_DASH  = 8'h2D; // '-'
    localparam logic [7:0] CHAR_SPACE = 8'h20; // ' '
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ST_BAD_PAD   = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL = 3'd3;
    localparam logic [2:0] ST_NONCANON  = 3'd4;

    localparam logic [2:0] PAD_COUNT_MAX = 3'd7;

    typedef enum logic [1:0] {
        CLS_SYMBOL,
        CLS_PAD,
        CLS_INVALID,
        CLS_END
    } b32d_class_t;

    typedef struct packed {
        b32d_class_t cls;
        logic [4:0]  value;
    } b32d_item_t;

    typedef struct packed {
        logic        is_byte;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] byte_count;
        logic        last;
    } b32d_result_t;

    // Padding length expected for a given symbol count modulo eight.
    function automatic logic [2:0] pad_expected(input logic [2:0] rem);
        logic [2:0] pad;
        begin
            case (rem)
                3'd2:    pad = 3'd6;
                3'd4:    pad = 3'd4;
                3'd5:    pad = 3'd3;
                3'd7:    pad = 3'd1;
                default: pad = 3'd0;
            endcase
            return pad;
        end
    endfunction

endpackage

// File: sv/b32d_front.sv
// ============================================================================
// b32d_front
// Input side: accept requests, classify characters, drop skipped ones.
// ============================================================================
module b32d_front
    import b32d_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       kind,
    input  logic [7:0] character,
    input  logic       q_full,
    output logic       push,
    output b32d_item_t item
);

    logic skip;
    logic [7:0] diff;

    assign s_tready = !q_full;

    always_comb
    begin
        skip       = 1'b0;
        item.cls   = CLS_INVALID;
        item.value = '0;
        diff       = '0;
        if (kind)
        begin
            item.cls = CLS_END;
        end
        else if (character == CHAR_SPACE || character == CHAR_DASH)
        begin
            skip = 1'b1;
        end
        else if (character == CHAR_PAD)
        begin
            item.cls = CLS_PAD;
        end
        else if (character >= CHAR_UP_A && character <= CHAR_UP_Z)
        begin
            diff       = character - CHAR_UP_A;
            item.cls   = CLS_SYMBOL;
            item.value = diff[4:0];
        end
        else if (character >= CHAR_LO_A && character <= CHAR_LO_Z)
        begin
            diff       = character - CHAR_LO_A;
            item.cls   = CLS_SYMBOL;
            item.value = diff[4:0];
        end
        else if (character >= CHAR_TWO && character <= CHAR_SEVEN)
        begin
            diff       = character - CHAR_TWO + 8'(LETTER_COUNT);
            item.cls   = CLS_SYMBOL;
            item.value = diff[4:0];
        end
    end

    // Spaces and dashes never touch state: drop them here.
    assign push = s_tvalid && s_tready && !skip;

endmodule

// File: sv/b32d_queue.sv
// ============================================================================
// b32d_queue
// Short first-in first-out queue of classified items.
// ============================================================================
module b32d_queue
    import b32d_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  b32d_item_t                 push_item,
    input  logic                       pop,
    output b32d_item_t                 pop_item,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b32d_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count    = count_reg;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/b32d_back.sv
// ============================================================================
// b32d_back
// Execution side: bit accumulator, padding and error tracking, result stage.
// ============================================================================
module b32d_back
    import b32d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  b32d_item_t   item,
    output logic         pop,
    input  logic [15:0]  capacity,
    output logic         m_tvalid,
    input  logic         m_tready,
    output b32d_result_t result
);

    logic [11:0] buf_reg, buf_next;
    logic [3:0]  held_reg, held_next;
    logic [15:0] written_reg, written_next;
    logic [2:0]  mod8_reg, mod8_next;
    logic        any_reg, any_next;
    logic        pad_seen_reg, pad_seen_next;
    logic [2:0]  pad_cnt_reg, pad_cnt_next;
    logic [2:0]  err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    b32d_result_t out_res_reg;

    logic         take;
    logic         emit;
    b32d_result_t res;
    logic [2:0]   final_st;
    logic [11:0]  shifted;
    logic [3:0]   held_sum;
    logic [3:0]   held_left;
    logic [11:0]  keep_mask;

    assign take     = !q_empty && (!out_valid_reg || m_tready);
    assign pop      = take;
    assign m_tvalid = out_valid_reg;
    assign result   = out_res_reg;

    // End-of-string checks in priority order.
    always_comb
    begin
        if (err_reg != ST_OK)
            final_st = err_reg;
        else if (!any_reg)
            final_st = ST_BAD_CHAR;
        else if (!(mod8_reg == 3'd0 || mod8_reg == 3'd2 || mod8_reg == 3'd4 ||
                   mod8_reg == 3'd5 || mod8_reg == 3'd7))
            final_st = ST_NONCANON;
        else if (held_reg != 4'd0 && buf_reg != 12'd0)
            final_st = ST_NONCANON;
        else if (pad_cnt_reg != 3'd0 &&
                 (pad_cnt_reg != pad_expected(mod8_reg) ||
                  (mod8_reg + pad_cnt_reg) != 3'd0))
            final_st = ST_BAD_PAD;
        else
            final_st = ST_OK;
    end

    always_comb
    begin
        shifted   = {buf_reg[6:0], item.value};
        held_sum  = held_reg + 4'(SYMBOL_BITS);
        held_left = held_sum - 4'(BYTE_BITS);
        keep_mask = (12'd1 << held_left) - 12'd1;
    end

    always_comb
    begin
        buf_next      = buf_reg;
        held_next     = held_reg;
        written_next  = written_reg;
        mod8_next     = mod8_reg;
        any_next      = any_reg;
        pad_seen_next = pad_seen_reg;
        pad_cnt_next  = pad_cnt_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        res           = '0;
        if (take)
        begin
            unique case (item.cls)
                CLS_END:
                begin
                    emit           = 1'b1;
                    res.last       = 1'b1;
                    res.status     = final_st;
                    res.byte_count = (final_st == ST_OK) ? written_reg : 16'd0;
                    buf_next       = '0;
                    held_next      = '0;
                    written_next   = '0;
                    mod8_next      = '0;
                    any_next       = 1'b0;
                    pad_seen_next  = 1'b0;
                    pad_cnt_next   = '0;
                    err_next       = ST_OK;
                end
                CLS_PAD:
                begin
                    if (err_reg == ST_OK)
                    begin
                        pad_seen_next = 1'b1;
                        if (pad_cnt_reg != PAD_COUNT_MAX)
                            pad_cnt_next = pad_cnt_reg + 3'd1;
                    end
                end
                CLS_INVALID:
                begin
                    if (err_reg == ST_OK)
                        err_next = pad_seen_reg ? ST_BAD_PAD : ST_BAD_CHAR;
                end
                CLS_SYMBOL:
                begin
                    if (err_reg == ST_OK)
                    begin
                        if (pad_seen_reg)
                        begin
                            err_next = ST_BAD_PAD;
                        end
                        else
                        begin
                            any_next  = 1'b1;
                            mod8_next = mod8_reg + 3'd1;
                            buf_next  = shifted;
                            held_next = held_sum;
                            if (held_sum >= 4'(BYTE_BITS))
                            begin
                                held_next = held_left;
                                if (written_reg >= capacity)
                                begin
                                    err_next = ST_TOO_SMALL;
                                end
                                else
                                begin
                                    emit          = 1'b1;
                                    res.is_byte   = 1'b1;
                                    res.data_byte = 8'(shifted >> held_left);
                                    buf_next      = shifted & keep_mask;
                                    written_next  = written_reg + 16'd1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            written_reg   <= '0;
            mod8_reg      <= '0;
            any_reg       <= 1'b0;
            pad_seen_reg  <= 1'b0;
            pad_cnt_reg   <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            written_reg   <= written_next;
            mod8_reg      <= mod8_next;
            any_reg       <= any_next;
            pad_seen_reg  <= pad_seen_next;
            pad_cnt_reg   <= pad_cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_res_reg <= res;
    end

endmodule

// File: sv/base32_strict_decoder_core.sv
// ============================================================================
// base32_strict_decoder_core
// Strict base32 stream decoder: one character request in, data bytes and a
// final status out.
// ============================================================================
// Feed one ASCII character per request (tuser low), or an end marker
// (tuser high). Letters of either case and digits 2 to 7 are symbols; spaces
// and dashes are skipped; '=' opens padding. Each symbol adds five bits, and a
// data byte leaves as soon as eight bits are held. The first error is latched
// and later characters are ignored until the end marker, which returns one
// status result (tlast high) carrying the byte count when the status is ok,
// and then clears the stream state. On a bad status, discard the bytes
// already delivered. The block takes one request per clock while its queue has
// room and gives at most one result per request; the front classifier and the
// back accumulator are parted by a queue of QUEUE_DEPTH entries, so a result
// passes through a queue entry and then the output register, and the queue
// lets further requests in while a result waits. Write the capacity register
// only while no string is in flight; its reset value is 65535.
module base32_strict_decoder_core
    import b32d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Character requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] kind: 1 = end of string
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [10:8] status,
                                   // [26:11] byte_count, [31:27] zero
    output logic        m_tuser,   // [0] is_byte
    output logic        m_tlast,
    // Capacity register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    `include "base32_strict_decoder_core_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]      capacity_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [CNT_W-1:0] q_count;
    b32d_item_t       front_item;
    b32d_item_t       back_item;
    b32d_result_t     result;

    // Capacity register: always ready, holds until rewritten.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= 16'hFFFF;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    // Classify and drop skipped characters.
    b32d_front u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .kind      (s_tuser),
        .character (s_tdata),
        .q_full    (q_full),
        .push      (q_push),
        .item      (front_item)
    );

    // Decouple the classifier from the accumulator.
    b32d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (back_item),
        .empty     (q_empty),
        .full      (q_full),
        .count     (q_count)
    );

    // Accumulate bits, track padding and errors, hold the result.
    b32d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .item     (back_item),
        .pop      (q_pop),
        .capacity (capacity_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {5'b0, result.byte_count, result.status, result.data_byte};
    assign m_tuser = result.is_byte;
    assign m_tlast = result.last;

    `B32D_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH),
        "queue count beyond depth")
    `B32D_ASSERT_NOW(a_byte_shape, m_tvalid && m_tuser,
        !m_tlast && m_tdata[10:8] == ST_OK && m_tdata[26:11] == 16'd0,
        "data byte result carries status fields")
    `B32D_ASSERT_NOW(a_fail_no_count, m_tvalid && m_tlast && m_tdata[10:8] != ST_OK,
        m_tdata[26:11] == 16'd0 && m_tdata[7:0] == 8'd0,
        "failed status carries a byte count")
    `B32D_ASSERT_NEXT(a_pop_when_queued, q_empty && !q_push, !q_pop,
        "pop from an empty queue")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the strict base32 decoder: random bursts of
// character requests, a stalling result sink and a local decoder that
// predicts every byte and final status.
// ============================================================================
module testbench;

    import b32d_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic        KIND_CHAR     = 1'b0;
    localparam logic        KIND_END      = 1'b1;
    localparam logic [5:0]  NOT_A_SYMBOL  = 6'd32;

    // Padding length that completes a group for each symbol count modulo eight.
    localparam logic [2:0] PAD_FOR_REM [8] = '{3'd0, 3'd0, 3'd6, 3'd0,
                                              3'd4, 3'd3, 3'd0, 3'd1};

    typedef struct packed {
        logic       kind;
        logic [7:0] character;
    } decode_req_t;

    // Ways in which a random string is spoilt on purpose.
    typedef enum int {
        DMG_NONE,
        DMG_BAD_CHAR,
        DMG_AFTER_PAD,
        DMG_PAD_COUNT,
        DMG_TAIL_BITS,
        DMG_REMAINDER,
        DMG_EMPTY,
        DMG_NOISE
    } damage_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    // Requests waiting for the sender, and results still owed by the block.
    decode_req_t  pending_requests[$];
    b32d_result_t expected_results[$];

    // Local copy of the decoder state and of the capacity register.
    logic [11:0] acc_bits;
    logic [3:0]  acc_count;
    logic [15:0] out_bytes;
    logic [2:0]  sym_phase;
    logic        seen_symbol;
    logic        in_padding;
    logic [2:0]  pad_run;
    logic [2:0]  sticky_err;
    logic [15:0] cap_limit;

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int rx_cycle = 0;
    logic [7:0] ready_pattern = 8'hFF;

    base32_strict_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Symbol value 0..31, or NOT_A_SYMBOL outside the alphabet.
    function automatic logic [5:0] symbol_of(input logic [7:0] c);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
            return 6'(c - CHAR_UP_A);
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
            return 6'(c - CHAR_LO_A);
        if (c >= CHAR_TWO && c <= CHAR_SEVEN)
            return 6'(c - CHAR_TWO + LETTER_COUNT);
        return NOT_A_SYMBOL;
    endfunction

    function automatic logic [2:0] end_status();
        if (sticky_err != ST_OK)
            return sticky_err;
        if (!seen_symbol)
            return ST_BAD_CHAR;
        // A string may stop only after 0, 2, 4, 5 or 7 symbols of a group.
        case (sym_phase) inside
            3'd1, 3'd3, 3'd6: return ST_NONCANON;
            default: ;
        endcase
        if (acc_count != 4'd0 && acc_bits != 12'd0)
            return ST_NONCANON;
        if (pad_run != 3'd0)
        begin
            if (pad_run != PAD_FOR_REM[sym_phase] || 3'(sym_phase + pad_run) != 3'd0)
                return ST_BAD_PAD;
        end
        return ST_OK;
    endfunction

    task automatic clear_decoder();
        acc_bits    = '0;
        acc_count   = '0;
        out_bytes   = '0;
        sym_phase   = '0;
        seen_symbol = 1'b0;
        in_padding  = 1'b0;
        pad_run     = '0;
        sticky_err  = ST_OK;
    endtask

    // Advance the local decoder by one accepted request.
    task automatic predict_request(input logic kind, input logic [7:0] ch);
        b32d_result_t res;
        logic [5:0]   sym;
        logic [2:0]   st;
        res = '0;
        sym = symbol_of(ch);
        if (kind == KIND_END)
        begin
            st = end_status();
            res.status     = st;
            res.byte_count = (st == ST_OK) ? out_bytes : 16'd0;
            res.last       = 1'b1;
            expected_results.push_back(res);
            clear_decoder();
        end
        else if (sticky_err == ST_OK && ch != CHAR_SPACE && ch != CHAR_DASH)
        begin
            if (ch == CHAR_PAD)
            begin
                in_padding = 1'b1;
                if (pad_run != PAD_COUNT_MAX)
                    pad_run = pad_run + 3'd1;
            end
            else if (in_padding)
                sticky_err = ST_BAD_PAD;
            else if (sym == NOT_A_SYMBOL)
                sticky_err = ST_BAD_CHAR;
            else
            begin
                seen_symbol = 1'b1;
                sym_phase   = sym_phase + 3'd1;
                acc_bits    = {acc_bits[6:0], sym[4:0]};
                acc_count   = acc_count + 4'(SYMBOL_BITS);
                if (acc_count >= 4'(BYTE_BITS))
                begin
                    acc_count = acc_count - 4'(BYTE_BITS);
                    if (out_bytes >= cap_limit)
                        sticky_err = ST_TOO_SMALL;
                    else
                    begin
                        res.is_byte   = 1'b1;
                        res.data_byte = 8'(acc_bits >> acc_count);
                        acc_bits      = acc_bits & ((12'd1 << acc_count) - 12'd1);
                        out_bytes     = out_bytes + 16'd1;
                        expected_results.push_back(res);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of requests with random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            clear_decoder();
            cap_limit  = 16'hFFFF;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            // Hold the current request until it is taken.
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_requests[0].kind;
                    s_tdata  <= pending_requests[0].character;
                    void'(pending_requests.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left = burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: rotating stall pattern, plus long hold-offs while the sender
    // has plenty queued so that the block backs up into its input
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle = rx_cycle + 1;
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (holds_done < 2 && pending_requests.size() > 40)
            begin
                hold_left  = HOLD_CYCLES;
                holds_done = holds_done + 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_cycle % 64 == 0)
                    ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                                : (8'($urandom) | 8'h01);
                m_tready <= ready_pattern[rx_cycle % 8];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got tdata %0h tuser %0b",
                         $time, m_tdata, m_tuser);
                fail_count = fail_count + 1;
            end
            else
            begin
                check_field("is_byte", 16'(expected_results[0].is_byte), 16'(m_tuser));
                check_field("data_byte", 16'(expected_results[0].data_byte),
                            16'(m_tdata[7:0]));
                check_field("status", 16'(expected_results[0].status), 16'(m_tdata[10:8]));
                check_field("byte_count", expected_results[0].byte_count, m_tdata[26:11]);
                check_field("last", 16'(expected_results[0].last), 16'(m_tlast));
                void'(expected_results.pop_front());
            end
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void push_request(input logic kind, input logic [7:0] ch);
        decode_req_t req;
        req.kind      = kind;
        req.character = ch;
        pending_requests.push_back(req);
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_request(KIND_CHAR, s[i]);
    endtask

    function automatic logic [7:0] symbol_char(input int v, input bit lower);
        if (v >= LETTER_COUNT)
            return 8'(CHAR_TWO + v - LETTER_COUNT);
        return lower ? 8'(CHAR_LO_A + v) : 8'(CHAR_UP_A + v);
    endfunction

    // Encode random bytes, spoil the string in one chosen way, queue it with
    // its end marker. Returns the number of requests queued.
    function automatic int queue_random_string();
        logic [7:0] text[$];
        logic [5:0] sym;
        logic [7:0] c;
        damage_t    dmg;
        int         pick;
        int         nbytes;
        int         acc;
        int         nbits;
        int         pads;
        pick = $urandom_range(0, 99);
        if (pick < 55)      dmg = DMG_NONE;
        else if (pick < 62) dmg = DMG_BAD_CHAR;
        else if (pick < 69) dmg = DMG_AFTER_PAD;
        else if (pick < 76) dmg = DMG_PAD_COUNT;
        else if (pick < 82) dmg = DMG_TAIL_BITS;
        else if (pick < 88) dmg = DMG_REMAINDER;
        else if (pick < 92) dmg = DMG_EMPTY;
        else                dmg = DMG_NOISE;

        // Mostly short strings, a few long ones.
        nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        acc   = 0;
        nbits = 0;
        repeat (nbytes)
        begin
            acc   = (acc << 8) | $urandom_range(0, 255);
            nbits = nbits + 8;
            while (nbits >= 5)
            begin
                nbits = nbits - 5;
                text.push_back(symbol_char((acc >> nbits) & 31, $urandom_range(0, 3) == 0));
                acc = acc & ((1 << nbits) - 1);
            end
        end
        if (nbits != 0)
            text.push_back(symbol_char((acc << (5 - nbits)) & 31, $urandom_range(0, 3) == 0));
        pads = (8 - text.size() % 8) % 8;

        case (dmg)
            DMG_NONE:
            begin
                if ($urandom_range(0, 1) == 1)
                    repeat (pads) text.push_back(CHAR_PAD);
            end
            DMG_BAD_CHAR:
            begin
                do
                begin
                    c   = 8'($urandom_range(0, 255));
                    sym = symbol_of(c);
                end
                while (sym != NOT_A_SYMBOL || c == CHAR_SPACE || c == CHAR_DASH
                       || c == CHAR_PAD);
                text.insert($urandom_range(0, text.size()), c);
            end
            DMG_AFTER_PAD:
            begin
                repeat ((pads == 0) ? 1 : pads) text.push_back(CHAR_PAD);
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CHAR_SPACE || c == CHAR_DASH || c == CHAR_PAD);
                text.push_back(c);
            end
            DMG_PAD_COUNT:
                repeat ($urandom_range(1, 10)) text.push_back(CHAR_PAD);
            DMG_TAIL_BITS:
            begin
                text[text.size() - 1] = symbol_char($urandom_range(0, 31), 1'b0);
                repeat (pads) text.push_back(CHAR_PAD);
            end
            DMG_REMAINDER:
            begin
                if (text.size() > 3)
                    repeat ($urandom_range(1, 3)) void'(text.pop_back());
            end
            DMG_EMPTY:
                text.delete();
            default:
            begin
                text.delete();
                repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
            end
        endcase

        // Sprinkle skipped separators now and then.
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
                text.insert($urandom_range(0, text.size()),
                            ($urandom_range(0, 1) == 1) ? CHAR_SPACE : CHAR_DASH);

        foreach (text[i])
            push_request(KIND_CHAR, text[i]);
        push_request(KIND_END, 8'($urandom_range(0, 255)));
        return text.size() + 1;
    endfunction

    task automatic queue_random(input int count);
        int queued;
        queued = 0;
        while (queued < count)
            queued = queued + queue_random_string();
    endtask

    // Wait until everything sent has been answered, then let the pipe empty.
    task automatic settle();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_limit = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset capacity.
        push_request(KIND_END, 8'h00);          // nothing decoded
        push_text("MY======");                  // one byte, full padding
        push_request(KIND_END, 8'hFF);
        push_text("m y-");                      // lower case with separators
        push_request(KIND_END, 8'h00);
        push_request(KIND_CHAR, 8'hFF);         // invalid, then ignored
        push_request(KIND_CHAR, CHAR_UP_A);
        push_request(KIND_END, 8'h00);
        push_text("A=A");                       // symbol after padding
        push_request(KIND_END, 8'h00);
        push_text("MZ");                        // nonzero leftover bits
        push_request(KIND_END, 8'h00);
        settle();

        queue_random(100);
        settle();

        write_capacity(16'd0);
        queue_random(60);
        settle();

        write_capacity(16'd4);
        queue_random(80);
        settle();

        write_capacity(16'hFFFF);
        queue_random(120);
        settle();

        write_capacity(16'($urandom_range(1, 20)));
        queue_random(120);
        settle();

        write_capacity(16'($urandom_range(0, 65535)));
        queue_random(60);
        settle();

        write_capacity(16'd1);
        queue_random(60);
        settle();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
